>>> hdl/ftsa_pkg.sv
// Shared types and constants for the fixed-step tick accumulator.
package ftsa_pkg;

  localparam int unsigned STEP_W    = 20;
  localparam int unsigned CALLS_W   = 8;
  localparam int unsigned WINDOW_W  = 26;
  localparam int unsigned CFG_W     = 26;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DELTA_W   = 24;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned FRAMES_W  = 24;
  localparam int unsigned RATE_W    = 30;
  localparam int unsigned RATIO_W   = 15;

  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = 1;
  localparam int unsigned Q_CNT_W   = 2;

  localparam int unsigned DIV_NUM_W = 56;
  localparam int unsigned DIV_DEN_W = 32;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_FIXED_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CALLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_WINDOW = 2'd2;

  localparam logic [STEP_W-1:0]   FIXED_STEP_RESET    = 20'd16667;
  localparam logic [CALLS_W-1:0]  MAX_CALLS_RESET     = 8'd5;
  localparam logic [WINDOW_W-1:0] REPORT_WINDOW_RESET = 26'd1000000;

  localparam logic [RATE_W-1:0]  RATE_LIMIT  = 30'd1000000000;
  localparam logic [RATIO_W-1:0] RATIO_LIMIT = 15'd25500;
  localparam logic [6:0]         RATIO_SCALE = 7'd100;

  typedef struct packed {
    logic [STEP_W-1:0]   fixed_step_us;
    logic [CALLS_W-1:0]  max_update_calls;
    logic [WINDOW_W-1:0] report_window_us;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [DELTA_W-1:0] delta;
  } fq_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

>>> hdl/fixed_step_tick_accumulator_unit.sv
// Top level: config registers, input queue, executor and shared divider.
// A frame that closes the report window adds three 56-step divisions.
// Throughput: one frame at a time; the tick loop and the shared divider set the rate.
// The input queue takes up to two frames while the executor is busy.
// Reset: synchronous; registers take their defaults, statistics and window clear.
module fixed_step_tick_accumulator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ftsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftsa_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            frame_valid,
  output logic                            frame_ready,
  input  logic [ftsa_pkg::DELTA_W-1:0]    frame_delta_us,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [ftsa_pkg::CALLS_W-1:0]    tick_count,
  output logic [ftsa_pkg::DELTA_W-1:0]    min_frame_us,
  output logic [ftsa_pkg::DELTA_W-1:0]    max_frame_us,
  output logic                            report_valid,
  output logic [ftsa_pkg::DELTA_W-1:0]    avg_frame_us,
  output logic [ftsa_pkg::RATE_W-1:0]     avg_rate_millifps,
  output logic [ftsa_pkg::RATIO_W-1:0]    tick_ratio_pct
);

  ftsa_pkg::cfg_t     cfg;
  ftsa_pkg::fq_t      head;
  ftsa_pkg::div_req_t div_req;
  ftsa_pkg::div_rsp_t div_rsp;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fixed_step_us    <= ftsa_pkg::FIXED_STEP_RESET;
      cfg.max_update_calls <= ftsa_pkg::MAX_CALLS_RESET;
      cfg.report_window_us <= ftsa_pkg::REPORT_WINDOW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ftsa_pkg::REG_FIXED_STEP:
          cfg.fixed_step_us <= cfg_data[ftsa_pkg::STEP_W-1:0];
        ftsa_pkg::REG_MAX_CALLS:
          cfg.max_update_calls <= cfg_data[ftsa_pkg::CALLS_W-1:0];
        ftsa_pkg::REG_REPORT_WINDOW:
          cfg.report_window_us <= cfg_data[ftsa_pkg::WINDOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ftsa_front u_front (
    .clk            (clk),
    .rst            (rst),
    .frame_valid    (frame_valid),
    .frame_ready    (frame_ready),
    .frame_delta_us (frame_delta_us),
    .pop            (pop),
    .head           (head)
  );

  ftsa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ftsa_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .head              (head),
    .pop               (pop),
    .div_req           (div_req),
    .div_rsp           (div_rsp),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .tick_count        (tick_count),
    .min_frame_us      (min_frame_us),
    .max_frame_us      (max_frame_us),
    .report_valid      (report_valid),
    .avg_frame_us      (avg_frame_us),
    .avg_rate_millifps (avg_rate_millifps),
    .tick_ratio_pct    (tick_ratio_pct)
  );

endmodule

>>> hdl/ftsa_front.sv
// Input side: accepts frame beats into a two-entry queue.
module ftsa_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          frame_valid,
  output logic                          frame_ready,
  input  logic [ftsa_pkg::DELTA_W-1:0]  frame_delta_us,
  input  logic                          pop,
  output ftsa_pkg::fq_t                 head
);

  logic [ftsa_pkg::DELTA_W-1:0] slot [ftsa_pkg::Q_DEPTH];
  logic [ftsa_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [ftsa_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [ftsa_pkg::Q_CNT_W-1:0] count;
  logic                         push;

  assign frame_ready = count != ftsa_pkg::Q_CNT_W'(ftsa_pkg::Q_DEPTH);
  assign push        = frame_valid && frame_ready;
  assign head.valid  = count != '0;
  assign head.delta  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= frame_delta_us;
        wr_ptr       <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

>>> hdl/ftsa_div.sv
// Shared restoring divider, one quotient bit per cycle.
module ftsa_div (
  input  logic                clk,
  input  logic                rst,
  input  ftsa_pkg::div_req_t  req,
  output ftsa_pkg::div_rsp_t  rsp
);

  logic                             busy;
  logic                             done;
  logic [ftsa_pkg::DIV_CNT_W-1:0]   cnt;
  logic [ftsa_pkg::DIV_NUM_W-1:0]   nq;
  logic [ftsa_pkg::DIV_DEN_W-1:0]   rem;
  logic [ftsa_pkg::DIV_DEN_W-1:0]   den;
  logic [ftsa_pkg::DIV_DEN_W:0]     shifted;
  logic [ftsa_pkg::DIV_DEN_W:0]     diff;
  logic                             fits;

  always_comb begin
    shifted = {rem, nq[ftsa_pkg::DIV_NUM_W-1]};
    fits    = shifted >= {1'b0, den};
    diff    = shifted - {1'b0, den};
  end

  assign rsp.done = done;
  assign rsp.quo  = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == ftsa_pkg::DIV_CNT_W'(1));
      if (req.start) begin
        nq   <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= ftsa_pkg::DIV_CNT_W'(ftsa_pkg::DIV_NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? diff[ftsa_pkg::DIV_DEN_W-1:0] : shifted[ftsa_pkg::DIV_DEN_W-1:0];
        nq  <= {nq[ftsa_pkg::DIV_NUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == ftsa_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  a_last_step_done: assert property (@(posedge clk) disable iff (rst)
    (busy && !req.start && cnt == ftsa_pkg::DIV_CNT_W'(1)) |=> (done && !busy))
    else $error("divider did not finish after last step");

endmodule

>>> hdl/ftsa_back.sv
// Execution side: tick loop, frame statistics, window report sequencing.
module ftsa_back (
  input  logic                           clk,
  input  logic                           rst,
  input  ftsa_pkg::cfg_t                 cfg,
  input  ftsa_pkg::fq_t                  head,
  output logic                           pop,
  output ftsa_pkg::div_req_t             div_req,
  input  ftsa_pkg::div_rsp_t             div_rsp,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [ftsa_pkg::CALLS_W-1:0]   tick_count,
  output logic [ftsa_pkg::DELTA_W-1:0]   min_frame_us,
  output logic [ftsa_pkg::DELTA_W-1:0]   max_frame_us,
  output logic                           report_valid,
  output logic [ftsa_pkg::DELTA_W-1:0]   avg_frame_us,
  output logic [ftsa_pkg::RATE_W-1:0]    avg_rate_millifps,
  output logic [ftsa_pkg::RATIO_W-1:0]   tick_ratio_pct
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_STAT,
    ST_PREP,
    ST_DIV_FRAME,
    ST_DIV_RATE,
    ST_DIV_RATIO,
    ST_OUT
  } state_t;

  localparam int unsigned RATE_PROD_W  = ftsa_pkg::FRAMES_W + ftsa_pkg::RATE_W;
  localparam int unsigned RATIO_PROD_W = ftsa_pkg::ACC_W + 7;

  state_t                          state;
  logic [ftsa_pkg::ACC_W-1:0]      acc;
  logic [ftsa_pkg::DELTA_W-1:0]    delta;
  logic [ftsa_pkg::CALLS_W-1:0]    ticks;
  logic [ftsa_pkg::DELTA_W-1:0]    shortest;
  logic [ftsa_pkg::DELTA_W-1:0]    longest;
  logic [ftsa_pkg::ACC_W-1:0]      wtime;
  logic [ftsa_pkg::FRAMES_W-1:0]   wframes;
  logic [ftsa_pkg::ACC_W-1:0]      wticks;
  logic                            report;
  logic [ftsa_pkg::DELTA_W-1:0]    avg_frame;
  logic [ftsa_pkg::RATE_W-1:0]     avg_rate;
  logic [ftsa_pkg::RATIO_W-1:0]    ratio;
  logic [RATE_PROD_W-1:0]          rate_prod;
  logic [RATIO_PROD_W-1:0]         ratio_prod;

  logic [ftsa_pkg::ACC_W-1:0]      step32;
  logic [ftsa_pkg::ACC_W-1:0]      wtime_next;
  logic [ftsa_pkg::FRAMES_W-1:0]   wframes_next;
  logic                            report_next;
  logic [RATE_PROD_W-1:0]          rate_prod_next;
  logic [RATIO_PROD_W-1:0]         ratio_prod_next;

  function automatic logic [ftsa_pkg::ACC_W-1:0] sat_add(
    input logic [ftsa_pkg::ACC_W-1:0] a,
    input logic [ftsa_pkg::ACC_W-1:0] b
  );
    logic [ftsa_pkg::ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ftsa_pkg::ACC_W] ? '1 : s[ftsa_pkg::ACC_W-1:0];
  endfunction

  always_comb begin
    step32          = ftsa_pkg::ACC_W'(cfg.fixed_step_us);
    wtime_next      = sat_add(wtime, ftsa_pkg::ACC_W'(delta));
    wframes_next    = (wframes == '1) ? wframes : wframes + 1'b1;
    report_next     = wtime_next >= ftsa_pkg::ACC_W'(cfg.report_window_us);
    rate_prod_next  = RATE_PROD_W'(wframes) * RATE_PROD_W'(ftsa_pkg::RATE_LIMIT);
    ratio_prod_next = RATIO_PROD_W'(wticks) * RATIO_PROD_W'(ftsa_pkg::RATIO_SCALE);
  end

  assign pop = (state == ST_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result_valid  <= 1'b0;
      div_req.start <= 1'b0;
      acc           <= '0;
      shortest      <= '1;
      longest       <= '0;
      wtime         <= '0;
      wframes       <= '0;
      wticks        <= '0;
      report        <= 1'b0;
    end else begin
      div_req.start <= (state == ST_PREP) ||
                       ((state == ST_DIV_FRAME || state == ST_DIV_RATE) && div_rsp.done);
      if (result_valid && result_ready && state != ST_OUT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head.valid) begin
            delta <= head.delta;
            acc   <= sat_add(acc, ftsa_pkg::ACC_W'(head.delta));
            ticks <= '0;
            state <= ST_TICK;
          end
        end
        ST_TICK: begin
          if (acc > step32 && ticks < cfg.max_update_calls) begin
            acc   <= acc - step32;
            ticks <= ticks + 1'b1;
          end else begin
            state <= ST_STAT;
          end
        end
        ST_STAT: begin
          if (delta < shortest) begin
            shortest <= delta;
          end
          if (delta > longest) begin
            longest <= delta;
          end
          wtime     <= wtime_next;
          wframes   <= wframes_next;
          wticks    <= sat_add(wticks, ftsa_pkg::ACC_W'(ticks));
          report    <= report_next;
          avg_frame <= '0;
          avg_rate  <= '0;
          ratio     <= '0;
          state     <= report_next ? ST_PREP : ST_OUT;
        end
        ST_PREP: begin
          rate_prod     <= rate_prod_next;
          ratio_prod    <= ratio_prod_next;
          div_req.num   <= ftsa_pkg::DIV_NUM_W'(wtime);
          div_req.den   <= ftsa_pkg::DIV_DEN_W'(wframes);
          state         <= ST_DIV_FRAME;
        end
        ST_DIV_FRAME: begin
          if (div_rsp.done) begin
            avg_frame     <= (|div_rsp.quo[ftsa_pkg::DIV_NUM_W-1:ftsa_pkg::DELTA_W]) ?
                             '1 : div_rsp.quo[ftsa_pkg::DELTA_W-1:0];
            div_req.num   <= ftsa_pkg::DIV_NUM_W'(rate_prod);
            div_req.den   <= wtime;
            state         <= ST_DIV_RATE;
          end
        end
        ST_DIV_RATE: begin
          if (div_rsp.done) begin
            avg_rate      <= (div_rsp.quo > ftsa_pkg::DIV_NUM_W'(ftsa_pkg::RATE_LIMIT)) ?
                             ftsa_pkg::RATE_LIMIT : div_rsp.quo[ftsa_pkg::RATE_W-1:0];
            div_req.num   <= ftsa_pkg::DIV_NUM_W'(ratio_prod);
            div_req.den   <= ftsa_pkg::DIV_DEN_W'(wframes);
            state         <= ST_DIV_RATIO;
          end
        end
        ST_DIV_RATIO: begin
          if (div_rsp.done) begin
            ratio   <= (div_rsp.quo > ftsa_pkg::DIV_NUM_W'(ftsa_pkg::RATIO_LIMIT)) ?
                       ftsa_pkg::RATIO_LIMIT : div_rsp.quo[ftsa_pkg::RATIO_W-1:0];
            wtime   <= '0;
            wframes <= '0;
            wticks  <= '0;
            state   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid      <= 1'b1;
            tick_count        <= ticks;
            min_frame_us      <= shortest;
            max_frame_us      <= longest;
            report_valid      <= report;
            avg_frame_us      <= avg_frame;
            avg_rate_millifps <= avg_rate;
            tick_ratio_pct    <= ratio;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_prep_on_report: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP) |-> report)
    else $error("division started without a closed window");

  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_RATIO && div_rsp.done) |=> (state == ST_OUT && wframes == '0))
    else $error("window not cleared after report");

endmodule

>>> verif/tick_stats_checker.sv
// Checker for the fixed-step tick accumulator: predicts each frame result and compares it.
`timescale 1ns / 100ps

module tick_stats_checker
  import ftsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 frame_valid,
  input  logic                 frame_ready,
  input  logic [DELTA_W-1:0]   frame_delta_us,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  logic [CALLS_W-1:0]   tick_count,
  input  logic [DELTA_W-1:0]   min_frame_us,
  input  logic [DELTA_W-1:0]   max_frame_us,
  input  logic                 report_valid,
  input  logic [DELTA_W-1:0]   avg_frame_us,
  input  logic [RATE_W-1:0]    avg_rate_millifps,
  input  logic [RATIO_W-1:0]   tick_ratio_pct,
  output int unsigned          mismatch_count,
  output int unsigned          results_due
);

  localparam longint unsigned RATE_SCALE = 64'd1000000000;

  typedef struct packed {
    logic [CALLS_W-1:0] ticks;
    logic [DELTA_W-1:0] shortest;
    logic [DELTA_W-1:0] longest;
    logic               report;
    logic [DELTA_W-1:0] avg_frame;
    logic [RATE_W-1:0]  rate;
    logic [RATIO_W-1:0] ratio;
  } frame_result_t;

  frame_result_t frame_results_due[$];

  logic [STEP_W-1:0]   fixed_step;
  logic [CALLS_W-1:0]  max_calls;
  logic [WINDOW_W-1:0] window_len;

  logic [ACC_W-1:0]    step_acc;
  logic [DELTA_W-1:0]  shortest;
  logic [DELTA_W-1:0]  longest;
  logic [ACC_W-1:0]    win_time;
  logic [FRAMES_W-1:0] win_frames;
  logic [ACC_W-1:0]    win_ticks;

  function automatic logic [ACC_W-1:0] add_sat(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[ACC_W] ? '1 : sum[ACC_W-1:0];
  endfunction

  function automatic frame_result_t account_frame(input logic [DELTA_W-1:0] delta);
    frame_result_t    r;
    int unsigned      issued;
    longint unsigned  quotient;
    r = '0;
    issued = 0;
    step_acc = add_sat(step_acc, ACC_W'(delta));
    while (step_acc > ACC_W'(fixed_step) && issued < max_calls) begin
      step_acc = step_acc - ACC_W'(fixed_step);
      issued++;
    end
    if (delta < shortest) shortest = delta;
    if (delta > longest) longest = delta;
    win_time = add_sat(win_time, ACC_W'(delta));
    if (win_frames != '1) win_frames = win_frames + 1'b1;
    win_ticks = add_sat(win_ticks, ACC_W'(issued));
    if (win_time >= ACC_W'(window_len)) begin
      r.report = 1'b1;
      quotient = 64'(win_time) / 64'(win_frames);
      r.avg_frame = (quotient > 64'hFFFFFF) ? '1 : quotient[DELTA_W-1:0];
      if (win_time == '0) begin
        r.rate = RATE_LIMIT;
      end else begin
        quotient = (64'(win_frames) * RATE_SCALE) / 64'(win_time);
        r.rate = (quotient > 64'(RATE_LIMIT)) ? RATE_LIMIT : quotient[RATE_W-1:0];
      end
      quotient = (64'(win_ticks) * 64'(RATIO_SCALE)) / 64'(win_frames);
      r.ratio = (quotient > 64'(RATIO_LIMIT)) ? RATIO_LIMIT : quotient[RATIO_W-1:0];
      win_time = '0;
      win_frames = '0;
      win_ticks = '0;
    end
    r.ticks = issued[CALLS_W-1:0];
    r.shortest = shortest;
    r.longest = longest;
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    frame_result_t want;
    if (rst) begin
      fixed_step = FIXED_STEP_RESET;
      max_calls = MAX_CALLS_RESET;
      window_len = REPORT_WINDOW_RESET;
      step_acc = '0;
      shortest = '1;
      longest = '0;
      win_time = '0;
      win_frames = '0;
      win_ticks = '0;
      mismatch_count = 0;
      frame_results_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FIXED_STEP:    fixed_step = cfg_data[STEP_W-1:0];
          REG_MAX_CALLS:     max_calls = cfg_data[CALLS_W-1:0];
          REG_REPORT_WINDOW: window_len = cfg_data[WINDOW_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (frame_results_due.size() == 0) begin
          $display("%0t: result beat with none expected, expected no beat, actual ticks %0d",
                   $time, tick_count);
          mismatch_count++;
        end else begin
          want = frame_results_due.pop_front();
          check_field("tick_count", want.ticks, tick_count);
          check_field("min_frame_us", want.shortest, min_frame_us);
          check_field("max_frame_us", want.longest, max_frame_us);
          check_field("report_valid", want.report, report_valid);
          check_field("avg_frame_us", want.avg_frame, avg_frame_us);
          check_field("avg_rate_millifps", want.rate, avg_rate_millifps);
          check_field("tick_ratio_pct", want.ratio, tick_ratio_pct);
        end
      end
      if (frame_valid && frame_ready)
        frame_results_due.push_back(account_frame(frame_delta_us));
    end
    results_due = frame_results_due.size();
  end

endmodule

>>> verif/testbench.sv
// Top of the tick accumulator testbench: clock, reset, frame stimulus, result stalls, verdict.
`timescale 1ns / 100ps

module testbench;
  import ftsa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int unsigned HOLD_CYCLES = 1200;
  localparam int unsigned IDLE_LIMIT  = 10000;
  localparam int unsigned DRAIN_CYCLES = 500;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 frame_valid;
  logic                 frame_ready;
  logic [DELTA_W-1:0]   frame_delta_us;
  logic                 result_valid;
  logic                 result_ready;
  logic [CALLS_W-1:0]   tick_count;
  logic [DELTA_W-1:0]   min_frame_us;
  logic [DELTA_W-1:0]   max_frame_us;
  logic                 report_valid;
  logic [DELTA_W-1:0]   avg_frame_us;
  logic [RATE_W-1:0]    avg_rate_millifps;
  logic [RATIO_W-1:0]   tick_ratio_pct;

  int unsigned mismatch_count;
  int unsigned results_due;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned idle_cycles;
  logic        hold_request;

  fixed_step_tick_accumulator_unit u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .frame_valid       (frame_valid),
    .frame_ready       (frame_ready),
    .frame_delta_us    (frame_delta_us),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .tick_count        (tick_count),
    .min_frame_us      (min_frame_us),
    .max_frame_us      (max_frame_us),
    .report_valid      (report_valid),
    .avg_frame_us      (avg_frame_us),
    .avg_rate_millifps (avg_rate_millifps),
    .tick_ratio_pct    (tick_ratio_pct)
  );

  tick_stats_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .frame_valid       (frame_valid),
    .frame_ready       (frame_ready),
    .frame_delta_us    (frame_delta_us),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .tick_count        (tick_count),
    .min_frame_us      (min_frame_us),
    .max_frame_us      (max_frame_us),
    .report_valid      (report_valid),
    .avg_frame_us      (avg_frame_us),
    .avg_rate_millifps (avg_rate_millifps),
    .tick_ratio_pct    (tick_ratio_pct),
    .mismatch_count    (mismatch_count),
    .results_due       (results_due)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (frame_valid && frame_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_frame(input logic [DELTA_W-1:0] delta);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      frame_valid <= 1'b0;
      @(negedge clk);
    end
    frame_valid <= 1'b1;
    frame_delta_us <= delta;
    do @(posedge clk); while (!frame_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    frame_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [DELTA_W-1:0] pick_delta(input int unsigned near);
    longint unsigned v;
    int unsigned     span;
    case ($urandom_range(9))
      0: v = 0;
      1: v = 64'hFFFFFF;
      2: v = 64'($urandom) & 64'hFFFFFF;
      3, 4, 5: begin
        span = near / 8 + 1;
        v = 64'(near) - 64'(span) + 64'($urandom_range(2 * span));
      end
      default: v = 64'($urandom_range(2 * near));
    endcase
    return (v > 64'hFFFFFF) ? '1 : v[DELTA_W-1:0];
  endfunction

  // upper data bits of the step and tick-limit writes carry junk that the register width must drop
  task automatic run_phase(input logic [STEP_W-1:0] step, input logic [CALLS_W-1:0] calls,
                           input logic [WINDOW_W-1:0] window, input int unsigned count,
                           input int unsigned near, input bit squeeze);
    write_reg(REG_FIXED_STEP, CFG_W'({$urandom, step}));
    write_reg(REG_MAX_CALLS, CFG_W'({$urandom, calls}));
    write_reg(REG_REPORT_WINDOW, window);
    for (int unsigned n = 0; n < count; n++) begin
      if (squeeze && n == 20) hold_request <= 1'b1;
      if (squeeze && n == count / 2) settle();
      send_frame(pick_delta(near));
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_FIXED_STEP;
    cfg_data = '0;
    frame_valid = 1'b0;
    frame_delta_us = '0;
    hold_request = 1'b0;
    tx_idle_pct = 18;
    rx_idle_pct = 85;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // defaults: step boundary, extremes of delta
    send_frame('0);
    send_frame('1);
    send_frame(24'd16667);
    send_frame(24'd16668);
    send_frame(24'd50002);
    send_frame(24'd1);
    settle();

    // zero fixed step
    write_reg(REG_FIXED_STEP, '0);
    write_reg(REG_MAX_CALLS, 26'd3);
    send_frame(24'd5);
    send_frame('0);
    send_frame(24'd100);
    settle();

    // zero tick limit
    write_reg(REG_MAX_CALLS, '0);
    send_frame(24'd1000);
    send_frame('1);
    settle();

    // zero window, masked writes, write past the register list
    write_reg(REG_REPORT_WINDOW, '0);
    write_reg(REG_FIXED_STEP, '1);
    write_reg(REG_MAX_CALLS, 26'h3FFFF01);
    write_reg(REG_NONE, CFG_W'($urandom));
    send_frame('0);
    send_frame(24'd1);
    send_frame('1);
    send_frame(24'd2);
    settle();

    write_reg(REG_REPORT_WINDOW, '1);
    write_reg(REG_MAX_CALLS, 26'd255);
    write_reg(REG_FIXED_STEP, 26'd1);
    send_frame('1);
    send_frame(24'd7);
    send_frame('0);
    settle();

    run_phase(20'd16667, 8'd5, 26'd1000000, 110, 16667, 1'b0);
    run_phase(STEP_W'($urandom_range(2000, 1)), CALLS_W'($urandom_range(255, 1)),
              WINDOW_W'($urandom_range(50000, 1)), 120, 1000, 1'b1);
    // saturate the step accumulator
    run_phase(STEP_W'($urandom_range(1048575, 1)), 8'd0, '1, 360, 16777215, 1'b0);

    tx_idle_pct = 85;
    rx_idle_pct = 18;
    run_phase(20'd1, 8'd255, WINDOW_W'($urandom_range(67108863)), 60, 5000, 1'b0);
    run_phase('1, 8'd255, WINDOW_W'($urandom_range(60000000, 1)), 100, 500000, 1'b0);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(STEP_W'($urandom_range(100000, 1)), CALLS_W'($urandom_range(8, 1)),
              WINDOW_W'($urandom_range(2000000, 1)), 120, 16667, 1'b0);
    run_phase(STEP_W'($urandom_range(1048575)), CALLS_W'($urandom_range(255)),
              '0, 60, 300, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> fixed_step_tick_accumulator_unit.f
hdl/ftsa_pkg.sv
hdl/ftsa_front.sv
hdl/ftsa_div.sv
hdl/ftsa_back.sv
hdl/fixed_step_tick_accumulator_unit.sv
verif/tick_stats_checker.sv
verif/testbench.sv
